// ----- hw/rtl/pcs_pkg.sv -----
// ----------------------------------------------------------------------------
// pcs_pkg
// shared constants and types for the pixel color search unit
// ----------------------------------------------------------------------------
package pcs_pkg;

   // largest screen dimension handled, coordinates fit in COORD_W bits
   localparam int MAX_DIM = 8192;
   localparam int COORD_W = $clog2(MAX_DIM);

   localparam int POS_W   = 16;
   localparam int RGB_W   = 24;
   localparam int TOL_W   = 8;
   localparam int SCR_W   = 14;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_START_X       = 4'd0,
      REG_START_Y       = 4'd1,
      REG_END_X         = 4'd2,
      REG_END_Y         = 4'd3,
      REG_TARGET_COLOR  = 4'd4,
      REG_TOLERANCE     = 4'd5,
      REG_SCREEN_WIDTH  = 4'd6,
      REG_SCREEN_HEIGHT = 4'd7
   } csr_index_type;

   localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 14'd1920;
   localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 14'd1080;

endpackage

// ----- hw/rtl/pixel_color_search_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_color_search_unit
// color search with per-channel tolerance over a clipped screen rectangle
// ----------------------------------------------------------------------------
// Usage:
//   csr_* writes one register per word (index, data). csr_ready is always
//   high. Every write to a known register restarts the scan; for one cycle
//   afterwards req_stall is raised while the clipped bounds are recomputed.
//   req_* takes the pixels of the clipped rectangle in raster order, one word
//   per cycle. A pixel lands in an input register and is matched and counted
//   from there; the unit sustains one pixel per clock when req_stall is low.
//   rsp_* gives one word (found, match_x, match_y) after the last pixel of the
//   rectangle has passed the input and result registers. The result sits in an
//   output register; while rsp_stall is high the input register still fills
//   and req_stall rises only once a pixel waits behind the held result.
//   If the clipped rectangle is empty, pixels are swallowed without effect.
//   Reset (synchronous) loads the default registers (1920x1080 screen,
//   corners at the origin), clears all hits and holds req_stall for one
//   cycle while the bounds settle.
// ----------------------------------------------------------------------------
module pixel_color_search_unit
   import pcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [RGB_W-1:0]      req_pixel_rgb,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   output logic [COORD_W-1:0]    rsp_match_x,
   output logic [COORD_W-1:0]    rsp_match_y
);

   // configuration registers
   logic [POS_W-1:0]   start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic [RGB_W-1:0]   target_color_ff;
   logic [TOL_W-1:0]   tolerance_ff;
   logic [SCR_W-1:0]   screen_width_ff, screen_height_ff;

   // clipped bounds
   logic [COORD_W-1:0] clip_l_ff, clip_r_ff, clip_t_ff, clip_b_ff;
   logic [COORD_W-1:0] clip_l_in, clip_r_in, clip_t_in, clip_b_in;
   logic               clip_empty_ff, clip_empty_in;
   logic               x_fwd_ff, x_fwd_in, y_fwd_ff, y_fwd_in;
   logic               settle_ff;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [RGB_W-1:0]   pixel_ff, pixel_in;

   // scan state
   logic               restart_ff, restart_in;
   logic [COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic               row_hit_ff, row_hit_in;
   logic [COORD_W-1:0] row_hit_x_ff, row_hit_x_in;
   logic               best_hit_ff, best_hit_in;
   logic [COORD_W-1:0] best_x_ff, best_x_in, best_y_ff, best_y_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [COORD_W-1:0] rsp_match_x_ff, rsp_match_x_in, rsp_match_y_ff, rsp_match_y_in;

   logic               csr_write, csr_known, accept, advance, process;
   logic               match, last_col, last_row, done, best_take;
   logic               row_hit_upd, best_hit_upd;
   logic [COORD_W-1:0] cx, cy, row_x_upd, bx, by;

   logic signed [POS_W:0] x1, x2, y1, y2, lo_x, hi_x, lo_y, hi_y;
   logic signed [POS_W:0] l_s, r_s, t_s, b_s, swm1, shm1;
   logic [SCR_W-1:0]      sw_lim, sh_lim;

   function automatic logic [7:0] chan_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // ---------------------------------------------------------------- clipping
   always_comb begin
      x1 = $signed({start_x_ff[POS_W-1], start_x_ff});
      x2 = $signed({end_x_ff[POS_W-1], end_x_ff});
      y1 = $signed({start_y_ff[POS_W-1], start_y_ff});
      y2 = $signed({end_y_ff[POS_W-1], end_y_ff});
      sw_lim = (screen_width_ff > SCR_W'(MAX_DIM)) ? SCR_W'(MAX_DIM) : screen_width_ff;
      sh_lim = (screen_height_ff > SCR_W'(MAX_DIM)) ? SCR_W'(MAX_DIM) : screen_height_ff;
      swm1 = $signed({3'b000, sw_lim}) - 17'sd1;
      shm1 = $signed({3'b000, sh_lim}) - 17'sd1;
      lo_x = (x1 < x2) ? x1 : x2;
      hi_x = (x1 < x2) ? x2 : x1;
      lo_y = (y1 < y2) ? y1 : y2;
      hi_y = (y1 < y2) ? y2 : y1;
      l_s = (lo_x < 17'sd0) ? 17'sd0 : lo_x;
      t_s = (lo_y < 17'sd0) ? 17'sd0 : lo_y;
      r_s = (hi_x > swm1) ? swm1 : hi_x;
      b_s = (hi_y > shm1) ? shm1 : hi_y;
      clip_empty_in = (r_s < l_s) || (b_s < t_s);
      clip_l_in = l_s[COORD_W-1:0];
      clip_r_in = r_s[COORD_W-1:0];
      clip_t_in = t_s[COORD_W-1:0];
      clip_b_in = b_s[COORD_W-1:0];
      x_fwd_in = (x1 <= x2);
      y_fwd_in = (y1 <= y2);
   end

   // ---------------------------------------------------------------- handshake
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      case (csr_index)
         REG_START_X, REG_START_Y, REG_END_X, REG_END_Y,
         REG_TARGET_COLOR, REG_TOLERANCE,
         REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT: csr_known = 1'b1;
         default:                             csr_known = 1'b0;
      endcase
   end

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = settle_ff || (in_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;
   assign process   = advance && !clip_empty_ff;

   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign pixel_in    = accept ? req_pixel_rgb : pixel_ff;

   // ---------------------------------------------------------------- scan step
   always_comb begin
      cx = restart_ff ? clip_l_ff : col_ff;
      cy = restart_ff ? clip_t_ff : row_ff;

      match = (chan_diff(pixel_ff[23:16], target_color_ff[23:16]) <= tolerance_ff) &&
              (chan_diff(pixel_ff[15:8],  target_color_ff[15:8])  <= tolerance_ff) &&
              (chan_diff(pixel_ff[7:0],   target_color_ff[7:0])   <= tolerance_ff);

      // reversed column direction keeps the rightmost hit
      row_hit_upd = row_hit_ff || match;
      row_x_upd   = (match && (!x_fwd_ff || !row_hit_ff)) ? cx : row_hit_x_ff;

      last_col = (cx == clip_r_ff);
      last_row = (cy == clip_b_ff);
      done     = last_col && last_row;

      // reversed row direction keeps the lowest row
      best_take    = last_col && row_hit_upd && (!y_fwd_ff || !best_hit_ff);
      best_hit_upd = best_hit_ff || best_take;
      bx           = best_take ? row_x_upd : best_x_ff;
      by           = best_take ? cy : best_y_ff;

      restart_in   = restart_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      row_hit_in   = row_hit_ff;
      row_hit_x_in = row_hit_x_ff;
      best_hit_in  = best_hit_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      if (process) begin
         restart_in   = 1'b0;
         row_hit_x_in = row_x_upd;
         best_x_in    = bx;
         best_y_in    = by;
         if (last_col) begin
            col_in      = clip_l_ff;
            row_in      = last_row ? clip_t_ff : COORD_W'(cy + 1'b1);
            row_hit_in  = 1'b0;
            best_hit_in = last_row ? 1'b0 : best_hit_upd;
         end else begin
            col_in      = COORD_W'(cx + 1'b1);
            row_in      = cy;
            row_hit_in  = row_hit_upd;
         end
      end

      rsp_found_in   = best_hit_upd;
      rsp_match_x_in = best_hit_upd ? bx : '0;
      rsp_match_y_in = best_hit_upd ? by : '0;
      if (process && done) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         end_x_ff         <= '0;
         end_y_ff         <= '0;
         target_color_ff  <= '0;
         tolerance_ff     <= '0;
         screen_width_ff  <= SCREEN_WIDTH_RST;
         screen_height_ff <= SCREEN_HEIGHT_RST;
         settle_ff        <= 1'b1;
         in_valid_ff      <= 1'b0;
         restart_ff       <= 1'b1;
         row_hit_ff       <= 1'b0;
         best_hit_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && csr_known) begin
            case (csr_index)
               REG_START_X:       start_x_ff       <= csr_data[POS_W-1:0];
               REG_START_Y:       start_y_ff       <= csr_data[POS_W-1:0];
               REG_END_X:         end_x_ff         <= csr_data[POS_W-1:0];
               REG_END_Y:         end_y_ff         <= csr_data[POS_W-1:0];
               REG_TARGET_COLOR:  target_color_ff  <= csr_data[RGB_W-1:0];
               REG_TOLERANCE:     tolerance_ff     <= csr_data[TOL_W-1:0];
               REG_SCREEN_WIDTH:  screen_width_ff  <= csr_data[SCR_W-1:0];
               REG_SCREEN_HEIGHT: screen_height_ff <= csr_data[SCR_W-1:0];
               default: begin
               end
            endcase
            // new registers must pass through the clip registers before the bounds are valid
            settle_ff   <= 1'b1;
            restart_ff  <= 1'b1;
            row_hit_ff  <= 1'b0;
            best_hit_ff <= 1'b0;
         end else begin
            settle_ff   <= 1'b0;
            restart_ff  <= restart_in;
            row_hit_ff  <= row_hit_in;
            best_hit_ff <= best_hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      clip_l_ff     <= clip_l_in;
      clip_r_ff     <= clip_r_in;
      clip_t_ff     <= clip_t_in;
      clip_b_ff     <= clip_b_in;
      clip_empty_ff <= clip_empty_in;
      x_fwd_ff      <= x_fwd_in;
      y_fwd_ff      <= y_fwd_in;
      pixel_ff      <= pixel_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      row_hit_x_ff  <= row_hit_x_in;
      best_x_ff     <= best_x_in;
      best_y_ff     <= best_y_in;
      if (!(rsp_valid_ff && rsp_stall)) begin
         rsp_found_ff   <= rsp_found_in;
         rsp_match_x_ff <= rsp_match_x_in;
         rsp_match_y_ff <= rsp_match_y_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_match_x = rsp_match_x_ff;
   assign rsp_match_y = rsp_match_y_ff;

   // ---------------------------------------------------------------- assertions
   // scan position stays inside the clipped rectangle once it is running
   a_counter_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (!restart_ff && !settle_ff && !clip_empty_ff) |->
         (col_ff >= clip_l_ff && col_ff <= clip_r_ff &&
          row_ff >= clip_t_ff && row_ff <= clip_b_ff))
      else $error("scan counter outside clipped rectangle");

   // a register write restarts the scan and drops all hits
   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_known) |=> (restart_ff && !best_hit_ff && !row_hit_ff && settle_ff))
      else $error("register write did not restart the scan");

   // a result without a match reports zero coordinates
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_match_x_ff == '0 && rsp_match_y_ff == '0))
      else $error("miss reported with nonzero coordinates");

endmodule
